FILE: rtl/core/lwde_pkg.sv
// Shared constants, codes and compare helpers for the line window dilate/erode block.
package lwde_pkg;

    localparam int PIX_W          = 8;
    localparam int WSIZE_W        = 4;
    localparam int MAX_WINDOW_DEF = 15;
    localparam int CFG_IDX_W      = 2;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_MORPH_MODE  = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        MODE_DILATE = 1'b0,
        MODE_ERODE  = 1'b1
    } morph_mode_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // Max for dilation, min for erosion.
    function automatic pixel_t pick(input morph_mode_t mode, input pixel_t a, input pixel_t b);
        pixel_t r;
        if (mode == MODE_ERODE) begin
            r = (a < b) ? a : b;
        end else begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

    // Neutral element of pick: never wins a compare.
    function automatic pixel_t ident(input morph_mode_t mode);
        pixel_t r;
        r = (mode == MODE_ERODE) ? '1 : '0;
        return r;
    endfunction

endpackage

FILE: rtl/core/line_window_dilate_erode_top.sv
// Top level: 1-D sliding window max/min over two pixel channels along one line.
// An accepted input beat's result beat is in the output register in the following cycle.
// Throughput: one pixel pair per cycle unless m_ready stalls; window shift line and a masked
// compare tree of depth clog2(MAX_WINDOW) sit between the input port and the output register.
// Reset (aresetn low, synchronous): window_size 3, dilation, fill count and output valid
// cleared; stored pixels are not cleared and never used in a result before being written.
module line_window_dilate_erode_top #(
    parameter int MAX_WINDOW = lwde_pkg::MAX_WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [lwde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwde_pkg::WSIZE_W-1:0]   cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lwde_pkg::PIX_W-1:0]     s_orig_pixel,
    input  logic [lwde_pkg::PIX_W-1:0]     s_inv_pixel,
    input  logic                           s_line_start,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lwde_pkg::PIX_W-1:0]     m_orig_out,
    output logic [lwde_pkg::PIX_W-1:0]     m_inv_out,
    output logic                           m_out_valid
);

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int LEVELS = $clog2(MAX_WINDOW);
    localparam int TREE_N = 1 << LEVELS;

    // configuration
    logic [lwde_pkg::WSIZE_W-1:0] window_size_reg;
    lwde_pkg::morph_mode_t        morph_mode_reg;
    logic [lwde_pkg::WSIZE_W-1:0] w_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= lwde_pkg::WSIZE_RESET;
            morph_mode_reg  <= lwde_pkg::MODE_DILATE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lwde_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                lwde_pkg::REG_MORPH_MODE:  morph_mode_reg  <= lwde_pkg::morph_mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        if (window_size_reg == '0) begin
            w_eff = lwde_pkg::WSIZE_W'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            w_eff = lwde_pkg::WSIZE_W'(MAX_WINDOW);
        end else begin
            w_eff = window_size_reg;
        end
    end

    // window shift line, index 0 newest
    lwde_pkg::pixel_t orig_win_reg [MAX_WINDOW];
    lwde_pkg::pixel_t inv_win_reg  [MAX_WINDOW];
    lwde_pkg::pixel_t orig_win_next[MAX_WINDOW];
    lwde_pkg::pixel_t inv_win_next [MAX_WINDOW];
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic accept;
    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        orig_win_next[0] = s_orig_pixel;
        inv_win_next[0]  = s_inv_pixel;
        for (int i = 1; i < MAX_WINDOW; i++) begin
            orig_win_next[i] = orig_win_reg[i-1];
            inv_win_next[i]  = inv_win_reg[i-1];
        end
        fill_next = s_line_start ? '0 : fill_reg;
        if (int'(fill_next) < MAX_WINDOW) begin
            fill_next = fill_next + FILL_W'(1);
        end
    end

    // masked compare tree over the updated window
    lwde_pkg::pixel_t orig_lvl[LEVELS+1][TREE_N];
    lwde_pkg::pixel_t inv_lvl [LEVELS+1][TREE_N];
    lwde_pkg::pixel_t id_pix;

    always_comb begin
        id_pix = lwde_pkg::ident(morph_mode_reg);
        for (int l = 0; l <= LEVELS; l++) begin
            for (int k = 0; k < TREE_N; k++) begin
                orig_lvl[l][k] = id_pix;
                inv_lvl[l][k]  = id_pix;
            end
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (i < int'(w_eff)) begin
                orig_lvl[0][i] = orig_win_next[i];
                inv_lvl[0][i]  = inv_win_next[i];
            end
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int k = 0; k < (TREE_N >> (l + 1)); k++) begin
                orig_lvl[l+1][k] = lwde_pkg::pick(morph_mode_reg,
                                                  orig_lvl[l][2*k], orig_lvl[l][2*k+1]);
                inv_lvl[l+1][k]  = lwde_pkg::pick(morph_mode_reg,
                                                  inv_lvl[l][2*k], inv_lvl[l][2*k+1]);
            end
        end
    end

    logic full_next;
    assign full_next = int'(fill_next) >= int'(w_eff);

    // control registers
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    lwde_pkg::pixel_t orig_out_reg, inv_out_reg;
    logic             out_valid_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                orig_win_reg[i] <= orig_win_next[i];
                inv_win_reg[i]  <= inv_win_next[i];
            end
            out_valid_reg <= full_next;
            orig_out_reg  <= full_next ? orig_lvl[LEVELS][0] : '0;
            inv_out_reg   <= full_next ? inv_lvl[LEVELS][0]  : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_orig_out  = orig_out_reg;
    assign m_inv_out   = inv_out_reg;
    assign m_out_valid = out_valid_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= MAX_WINDOW)
        else $error("fill count above window depth");

    a_beat_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result beat");

    a_start_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_line_start && (w_eff > lwde_pkg::WSIZE_W'(1)) |=> !m_out_valid)
        else $error("window reported full on first pixel of a line");

    a_zero_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_valid |-> (m_orig_out == '0) && (m_inv_out == '0))
        else $error("result fields not zero while window not full");

    a_unit_window: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (w_eff == lwde_pkg::WSIZE_W'(1))
        |=> m_out_valid && (m_orig_out == $past(s_orig_pixel))
            && (m_inv_out == $past(s_inv_pixel)))
        else $error("one-pixel window must pass the pixel through");
`endif

endmodule
